### rtl/orbit_camera_position_top_macros.svh
// Assertion macros for the orbit camera position block.
// Expects a clock i_clk and an active-low synchronous reset i_rst_n in scope.
`ifndef ORBIT_CAMERA_POSITION_TOP_MACROS_SVH
`define ORBIT_CAMERA_POSITION_TOP_MACROS_SVH

// Check at every clock edge, reset included.
`define ORB_ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

// Check at every clock edge outside reset.
`define ORB_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

`endif

### rtl/orb_pkg.sv
// Shared types, constants and helper functions for the orbit camera position block.
// No dependencies; used by every module of the block.
package orb_pkg;

    localparam int unsigned CFG_W       = 16;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned DIST_W      = 24;
    localparam int unsigned ANG_W       = 16;
    localparam int unsigned COORD_W     = 32;
    localparam int unsigned TRIG_W      = 16;

    localparam logic [DIST_W-1:0]       DIST_MAX   = 24'hFFFFFF;
    localparam logic [DIST_W-1:0]       RST_DIST   = 24'd25600;
    localparam logic [ANG_W-1:0]        RST_YAW    = 16'd0;
    localparam logic signed [ANG_W-1:0] RST_PITCH  = -16'sd5459;
    localparam logic [15:0]             RST_STEP   = 16'd26;
    localparam logic [15:0]             RST_GAIN   = 16'd2670;
    localparam logic [13:0]             RST_LIMIT  = 14'd16376;
    localparam logic [7:0]              RST_RATIO  = 8'd77;

    localparam int unsigned CORDIC_STEPS = 16;
    localparam int unsigned STEP_W       = 4;
    localparam int unsigned XY_W         = 34;
    localparam int unsigned Z_W          = 25;
    localparam logic signed [XY_W-1:0] CORDIC_K = 34'sd652032874;

    localparam int unsigned QDEPTH = 2;
    localparam int unsigned QPTR_W = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DISTANCE_STEP = 2'd0,
        CFG_TURN_GAIN     = 2'd1,
        CFG_PITCH_LIMIT   = 2'd2,
        CFG_HEIGHT_RATIO  = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic [15:0] distance_step;
        logic [15:0] turn_gain;
        logic [13:0] pitch_limit;
        logic [7:0]  height_ratio;
    } t_cfg;

    typedef struct packed {
        logic signed [15:0]        mouse_dx;
        logic signed [15:0]        mouse_dy;
        logic signed [COORD_W-1:0] target_x;
        logic signed [COORD_W-1:0] target_y;
        logic signed [COORD_W-1:0] target_z;
        logic [DIST_W-1:0]         distance;
    } t_job;

    // arctan(2^-i) in units of 2^24 per turn
    function automatic logic signed [Z_W-1:0] atan_lut(input logic [STEP_W-1:0] idx);
        logic signed [Z_W-1:0] v;
        unique case (idx)
            4'd0:  v = 25'sd2097152;
            4'd1:  v = 25'sd1238021;
            4'd2:  v = 25'sd654136;
            4'd3:  v = 25'sd332050;
            4'd4:  v = 25'sd166669;
            4'd5:  v = 25'sd83416;
            4'd6:  v = 25'sd41718;
            4'd7:  v = 25'sd20860;
            4'd8:  v = 25'sd10430;
            4'd9:  v = 25'sd5215;
            4'd10: v = 25'sd2608;
            4'd11: v = 25'sd1304;
            4'd12: v = 25'sd652;
            4'd13: v = 25'sd326;
            4'd14: v = 25'sd163;
            4'd15: v = 25'sd81;
        endcase
        return v;
    endfunction

    function automatic logic signed [COORD_W-1:0] sat32(input logic signed [33:0] v);
        logic signed [33:0]        hi;
        logic signed [33:0]        lo;
        logic signed [COORD_W-1:0] r;
        hi = 34'sd2147483647;
        lo = -34'sd2147483648;
        if (v > hi) begin
            r = 32'sh7FFFFFFF;
        end else if (v < lo) begin
            r = 32'sh80000000;
        end else begin
            r = v[COORD_W-1:0];
        end
        return r;
    endfunction

endpackage

### rtl/orb_front.sv
// Front end: accepts frame requests, steps the orbit distance and tracks the target.
// Pushes jobs that need a result into the queue; uses orb_pkg.
module orb_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic                              i_key_up,
    input  logic                              i_key_down,
    input  logic signed [15:0]                i_mouse_dx,
    input  logic signed [15:0]                i_mouse_dy,
    input  logic                              i_target_destroyed,
    input  logic signed [orb_pkg::COORD_W-1:0] i_target_x,
    input  logic signed [orb_pkg::COORD_W-1:0] i_target_y,
    input  logic signed [orb_pkg::COORD_W-1:0] i_target_z,
    input  logic [15:0]                       i_distance_step,
    input  logic                              i_full,
    output logic                              o_push,
    output orb_pkg::t_job                     o_job
);
    import orb_pkg::*;

    logic [DIST_W-1:0] r_distance;
    logic [DIST_W-1:0] n_distance;
    logic              r_tracking;
    logic              n_tracking;
    logic              accept;
    logic [DIST_W:0]   up_sum;
    logic [DIST_W-1:0] step_ext;
    logic [DIST_W-1:0] after_up;
    logic [DIST_W-1:0] after_down;

    assign o_stall  = i_full;
    assign accept   = i_valid && !i_full;
    assign step_ext = {8'b0, i_distance_step};
    assign up_sum   = {1'b0, r_distance} + {1'b0, step_ext};

    always_comb begin
        after_up = r_distance;
        if (i_key_up) begin
            after_up = (up_sum > {1'b0, DIST_MAX}) ? DIST_MAX : up_sum[DIST_W-1:0];
        end
        after_down = after_up;
        if (i_key_down) begin
            after_down = (after_up >= step_ext) ? (after_up - step_ext) : '0;
        end
        n_distance = accept ? after_down : r_distance;
        n_tracking = (accept && i_target_destroyed) ? 1'b0 : r_tracking;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_distance <= RST_DIST;
            r_tracking <= 1'b1;
        end else begin
            r_distance <= n_distance;
            r_tracking <= n_tracking;
        end
    end

    assign o_push          = accept && r_tracking && !i_target_destroyed;
    assign o_job.mouse_dx  = i_mouse_dx;
    assign o_job.mouse_dy  = i_mouse_dy;
    assign o_job.target_x  = i_target_x;
    assign o_job.target_y  = i_target_y;
    assign o_job.target_z  = i_target_z;
    assign o_job.distance  = after_down;

endmodule

### rtl/orb_queue.sv
// Short job queue between the front end and the back end.
// Register-based FIFO of orb_pkg::t_job entries.
module orb_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  orb_pkg::t_job i_data,
    output logic          o_full,
    input  logic          i_pop,
    output orb_pkg::t_job o_data,
    output logic          o_empty
);
    import orb_pkg::*;

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;
    logic [QPTR_W-1:0] n_wr_ptr;
    logic [QPTR_W-1:0] n_rd_ptr;
    logic [QPTR_W:0]   n_count;

    assign o_full  = (r_count == (QPTR_W+1)'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QDEPTH-1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QDEPTH-1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

### rtl/orb_cordic.sv
// Iterative CORDIC sine and cosine, one micro-rotation per clock.
// Q4.30 datapath, Q1.15 rounded and saturated results; uses orb_pkg.
module orb_cordic (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [orb_pkg::ANG_W-1:0]         i_angle,
    output logic                              o_done,
    output logic signed [orb_pkg::TRIG_W-1:0] o_sin,
    output logic signed [orb_pkg::TRIG_W-1:0] o_cos
);
    import orb_pkg::*;

    logic                     r_busy;
    logic                     r_done;
    logic [STEP_W-1:0]        r_step;
    logic signed [XY_W-1:0]   r_x;
    logic signed [XY_W-1:0]   r_y;
    logic signed [Z_W-1:0]    r_z;
    logic                     r_flip;
    logic signed [ANG_W:0]    ang_ext;
    logic signed [ANG_W:0]    ang_fold;
    logic                     fold_flip;
    logic signed [Z_W-1:0]    z_start;
    logic signed [XY_W-1:0]   sh_x;
    logic signed [XY_W-1:0]   sh_y;
    logic signed [Z_W-1:0]    atan_step;

    function automatic logic signed [TRIG_W-1:0] round_q15(
        input logic signed [XY_W-1:0] v,
        input logic                   flip
    );
        logic signed [XY_W:0] f;
        logic signed [XY_W:0] r;
        logic signed [XY_W:0] half;
        logic signed [XY_W:0] top;
        logic signed [XY_W:0] bot;
        logic signed [TRIG_W-1:0] q;
        half = (XY_W+1)'(16384);
        top  = (XY_W+1)'(32767);
        bot  = -(XY_W+1)'(32768);
        f    = {v[XY_W-1], v};
        if (flip) begin
            f = -f;
        end
        r = (f + half) >>> 15;
        if (r > top) begin
            q = 16'sh7FFF;
        end else if (r < bot) begin
            q = 16'sh8000;
        end else begin
            q = r[TRIG_W-1:0];
        end
        return q;
    endfunction

    // fold the angle into the right half plane
    always_comb begin
        ang_ext   = {i_angle[ANG_W-1], i_angle};
        ang_fold  = ang_ext;
        fold_flip = 1'b0;
        if (ang_ext > 17'sd16384) begin
            ang_fold  = ang_ext - 17'sd32768;
            fold_flip = 1'b1;
        end else if (ang_ext < -17'sd16384) begin
            ang_fold  = ang_ext + 17'sd32768;
            fold_flip = 1'b1;
        end
        z_start = {ang_fold, 8'b0};
    end

    assign sh_x      = r_x >>> r_step;
    assign sh_y      = r_y >>> r_step;
    assign atan_step = atan_lut(r_step);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(CORDIC_STEPS-1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= CORDIC_K;
            r_y    <= '0;
            r_z    <= z_start;
            r_flip <= fold_flip;
        end else if (r_busy) begin
            if (!r_z[Z_W-1]) begin
                r_x <= r_x - sh_y;
                r_y <= r_y + sh_x;
                r_z <= r_z - atan_step;
            end else begin
                r_x <= r_x + sh_y;
                r_y <= r_y - sh_x;
                r_z <= r_z + atan_step;
            end
        end
    end

    assign o_done = r_done;
    assign o_cos  = round_q15(r_x, r_flip);
    assign o_sin  = round_q15(r_y, r_flip);

endmodule

### rtl/orb_back.sv
// Back end: integrates yaw and pitch, runs two CORDIC units and places look and eye.
// Sequencer with shared multiply steps and an output register; uses orb_pkg, orb_cordic.
module orb_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  orb_pkg::t_cfg                      i_cfg,
    input  logic                               i_empty,
    input  orb_pkg::t_job                      i_job,
    output logic                               o_pop,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic signed [orb_pkg::COORD_W-1:0] o_look_x,
    output logic signed [orb_pkg::COORD_W-1:0] o_look_y,
    output logic signed [orb_pkg::COORD_W-1:0] o_look_z,
    output logic signed [orb_pkg::COORD_W-1:0] o_eye_x,
    output logic signed [orb_pkg::COORD_W-1:0] o_eye_y,
    output logic signed [orb_pkg::COORD_W-1:0] o_eye_z
);
    import orb_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_TURN  = 7'b0000010,
        S_ANGLE = 7'b0000100,
        S_TRIG  = 7'b0001000,
        S_MUL1  = 7'b0010000,
        S_MUL2  = 7'b0100000,
        S_SUM   = 7'b1000000
    } t_back_state;

    t_back_state               r_state;
    t_back_state               n_state;
    t_job                      r_job;
    logic [ANG_W-1:0]          r_yaw;
    logic signed [ANG_W-1:0]   r_pitch;
    logic [ANG_W-1:0]          n_yaw;
    logic signed [ANG_W-1:0]   n_pitch;
    logic signed [32:0]        r_qx;
    logic signed [32:0]        r_qy;
    logic signed [TRIG_W-1:0]  r_sy;
    logic signed [TRIG_W-1:0]  r_cy;
    logic signed [TRIG_W-1:0]  r_sp;
    logic signed [TRIG_W-1:0]  r_cp;
    logic signed [31:0]        r_m1;
    logic signed [31:0]        r_m2;
    logic [31:0]               r_hm;
    logic signed [40:0]        r_dsp;
    logic signed [56:0]        r_px;
    logic signed [56:0]        r_pz;
    logic [24:0]               r_h;
    logic signed [26:0]        r_oy;
    logic                      r_out_valid;
    logic signed [COORD_W-1:0] r_look_x;
    logic signed [COORD_W-1:0] r_look_y;
    logic signed [COORD_W-1:0] r_look_z;
    logic signed [COORD_W-1:0] r_eye_x;
    logic signed [COORD_W-1:0] r_eye_y;
    logic signed [COORD_W-1:0] r_eye_z;

    logic signed [24:0]        qx_f;
    logic signed [24:0]        qy_f;
    logic signed [25:0]        pitch_diff;
    logic signed [25:0]        lim_pos;
    logic signed [25:0]        lim_neg;
    logic signed [25:0]        pitch_clamped;
    logic signed [DIST_W:0]    dist_s;
    logic signed [41:0]        oy_neg;
    logic signed [41:0]        oy_sum;
    logic [32:0]               h_sum;
    logic signed [56:0]        px_sum;
    logic signed [56:0]        pz_sum;
    logic signed [26:0]        ox;
    logic signed [26:0]        oz;
    logic signed [33:0]        look_y_sum;
    logic signed [33:0]        eye_x_sum;
    logic signed [33:0]        eye_y_sum;
    logic signed [33:0]        eye_z_sum;
    logic                      slot_free;
    logic                      cordic_start;
    logic                      yaw_done;
    logic                      pitch_done;
    logic                      trig_done;
    logic signed [TRIG_W-1:0]  yaw_sin;
    logic signed [TRIG_W-1:0]  yaw_cos;
    logic signed [TRIG_W-1:0]  pitch_sin;
    logic signed [TRIG_W-1:0]  pitch_cos;

    assign o_pop        = (r_state == S_IDLE) && !i_empty;
    assign slot_free    = !r_out_valid || !i_stall;
    assign cordic_start = (r_state == S_ANGLE);
    assign trig_done    = yaw_done && pitch_done;

    // mouse step and pitch clamp
    always_comb begin
        qx_f          = r_qx[32:8];
        qy_f          = r_qy[32:8];
        n_yaw         = r_yaw - qx_f[ANG_W-1:0];
        pitch_diff    = {{10{r_pitch[ANG_W-1]}}, r_pitch} - {qy_f[24], qy_f};
        lim_pos       = {12'b0, i_cfg.pitch_limit};
        lim_neg       = -lim_pos;
        pitch_clamped = pitch_diff;
        if (pitch_diff < lim_neg) begin
            pitch_clamped = lim_neg;
        end else if (pitch_diff > lim_pos) begin
            pitch_clamped = lim_pos;
        end
        n_pitch = pitch_clamped[ANG_W-1:0];
    end

    orb_cordic u_cordic_yaw (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cordic_start),
        .i_angle (n_yaw),
        .o_done  (yaw_done),
        .o_sin   (yaw_sin),
        .o_cos   (yaw_cos)
    );

    orb_cordic u_cordic_pitch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cordic_start),
        .i_angle (n_pitch),
        .o_done  (pitch_done),
        .o_sin   (pitch_sin),
        .o_cos   (pitch_cos)
    );

    always_comb begin
        dist_s     = {1'b0, r_job.distance};
        oy_neg     = -{r_dsp[40], r_dsp};
        oy_sum     = oy_neg + 42'sd16384;
        h_sum      = {1'b0, r_hm} + 33'd128;
        px_sum     = r_px + 57'sd536870912;
        pz_sum     = r_pz + 57'sd536870912;
        ox         = px_sum[56:30];
        oz         = pz_sum[56:30];
        look_y_sum = {{2{r_job.target_y[31]}}, r_job.target_y} + {9'b0, r_h};
        eye_x_sum  = {{2{r_job.target_x[31]}}, r_job.target_x} + {{7{ox[26]}}, ox};
        eye_y_sum  = look_y_sum + {{7{r_oy[26]}}, r_oy};
        eye_z_sum  = {{2{r_job.target_z[31]}}, r_job.target_z} + {{7{oz[26]}}, oz};
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (!i_empty) n_state = S_TURN;
            S_TURN:  n_state = S_ANGLE;
            S_ANGLE: n_state = S_TRIG;
            S_TRIG:  if (trig_done) n_state = S_MUL1;
            S_MUL1:  n_state = S_MUL2;
            S_MUL2:  n_state = S_SUM;
            S_SUM:   if (slot_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_yaw       <= RST_YAW;
            r_pitch     <= RST_PITCH;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_ANGLE) begin
                r_yaw   <= n_yaw;
                r_pitch <= n_pitch;
            end
            if ((r_state == S_SUM) && slot_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
        if (r_state == S_TURN) begin
            r_qx <= r_job.mouse_dx * $signed({1'b0, i_cfg.turn_gain});
            r_qy <= r_job.mouse_dy * $signed({1'b0, i_cfg.turn_gain});
        end
        if ((r_state == S_TRIG) && trig_done) begin
            r_sy <= yaw_sin;
            r_cy <= yaw_cos;
            r_sp <= pitch_sin;
            r_cp <= pitch_cos;
        end
        if (r_state == S_MUL1) begin
            r_m1  <= r_cp * r_sy;
            r_m2  <= r_cp * r_cy;
            r_hm  <= r_job.distance * i_cfg.height_ratio;
            r_dsp <= dist_s * r_sp;
        end
        if (r_state == S_MUL2) begin
            r_px <= dist_s * r_m1;
            r_pz <= dist_s * r_m2;
            r_h  <= h_sum[32:8];
            r_oy <= oy_sum[41:15];
        end
        if ((r_state == S_SUM) && slot_free) begin
            r_look_x <= r_job.target_x;
            r_look_y <= sat32(look_y_sum);
            r_look_z <= r_job.target_z;
            r_eye_x  <= sat32(eye_x_sum);
            r_eye_y  <= sat32(eye_y_sum);
            r_eye_z  <= sat32(eye_z_sum);
        end
    end

    assign o_valid  = r_out_valid;
    assign o_look_x = r_look_x;
    assign o_look_y = r_look_y;
    assign o_look_z = r_look_z;
    assign o_eye_x  = r_eye_x;
    assign o_eye_y  = r_eye_y;
    assign o_eye_z  = r_eye_z;

endmodule

### rtl/orbit_camera_position_top.sv
// Orbit camera position, top level: configuration registers, front end, queue, back end.
// Depends on orb_pkg, orb_front, orb_queue, orb_back.
//
// The camera orbits a moving target: each frame request steps the orbit distance with the
// keys, turns yaw and pitch by the scaled mouse movement and returns the look point and the
// eye position in signed Q.8. The front end takes one request per clock while the two-entry
// queue has room; a request that gives no result (tracking lost, or the destroy flag set)
// finishes there. A request that gives a result runs the mouse multiplies, then the two
// 16-step CORDIC units (yaw and pitch side by side), then the placement multiplies; the back
// end takes one request at a time, but a result register lets the next request start while
// the last result waits. Configuration is to be written by the user only while the block is
// idle; the block itself does not enforce this.
module orbit_camera_position_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [orb_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [orb_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic                               i_key_up,
    input  logic                               i_key_down,
    input  logic signed [15:0]                 i_mouse_dx,
    input  logic signed [15:0]                 i_mouse_dy,
    input  logic                               i_target_destroyed,
    input  logic signed [orb_pkg::COORD_W-1:0] i_target_x,
    input  logic signed [orb_pkg::COORD_W-1:0] i_target_y,
    input  logic signed [orb_pkg::COORD_W-1:0] i_target_z,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic signed [orb_pkg::COORD_W-1:0] o_look_x,
    output logic signed [orb_pkg::COORD_W-1:0] o_look_y,
    output logic signed [orb_pkg::COORD_W-1:0] o_look_z,
    output logic signed [orb_pkg::COORD_W-1:0] o_eye_x,
    output logic signed [orb_pkg::COORD_W-1:0] o_eye_y,
    output logic signed [orb_pkg::COORD_W-1:0] o_eye_z
);
    import orb_pkg::*;

    t_cfg r_cfg;
    t_job push_job;
    t_job head_job;
    logic push;
    logic pop;
    logic full;
    logic empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.distance_step <= RST_STEP;
            r_cfg.turn_gain     <= RST_GAIN;
            r_cfg.pitch_limit   <= RST_LIMIT;
            r_cfg.height_ratio  <= RST_RATIO;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_DISTANCE_STEP: r_cfg.distance_step <= i_cfg_data;
                CFG_TURN_GAIN:     r_cfg.turn_gain     <= i_cfg_data;
                CFG_PITCH_LIMIT:   r_cfg.pitch_limit   <= i_cfg_data[13:0];
                CFG_HEIGHT_RATIO:  r_cfg.height_ratio  <= i_cfg_data[7:0];
            endcase
        end
    end

    orb_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_key_up           (i_key_up),
        .i_key_down         (i_key_down),
        .i_mouse_dx         (i_mouse_dx),
        .i_mouse_dy         (i_mouse_dy),
        .i_target_destroyed (i_target_destroyed),
        .i_target_x         (i_target_x),
        .i_target_y         (i_target_y),
        .i_target_z         (i_target_z),
        .i_distance_step    (r_cfg.distance_step),
        .i_full             (full),
        .o_push             (push),
        .o_job              (push_job)
    );

    orb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (head_job),
        .o_empty (empty)
    );

    orb_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_empty  (empty),
        .i_job    (head_job),
        .o_pop    (pop),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_look_x (o_look_x),
        .o_look_y (o_look_y),
        .o_look_z (o_look_z),
        .o_eye_x  (o_eye_x),
        .o_eye_y  (o_eye_y),
        .o_eye_z  (o_eye_z)
    );

endmodule

### rtl/orb_checker.sv
// Port-level checks for the orbit camera position top level, attached by bind.
// Depends on orb_pkg and orbit_camera_position_top_macros.svh.
`include "orbit_camera_position_top_macros.svh"

module orb_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               o_stall,
    input  logic                               o_valid,
    input  logic                               i_stall,
    input  logic signed [orb_pkg::COORD_W-1:0] o_look_x,
    input  logic signed [orb_pkg::COORD_W-1:0] o_look_y,
    input  logic signed [orb_pkg::COORD_W-1:0] o_look_z,
    input  logic signed [orb_pkg::COORD_W-1:0] o_eye_x,
    input  logic signed [orb_pkg::COORD_W-1:0] o_eye_y,
    input  logic signed [orb_pkg::COORD_W-1:0] o_eye_z
);

    logic [6*orb_pkg::COORD_W-1:0] res_bus;

    assign res_bus = {o_eye_z, o_eye_y, o_eye_x, o_look_z, o_look_y, o_look_x};

    `ORB_ASSERT_CLK(a_reset_clears_result, !i_rst_n |=> !o_valid, "result valid after reset")

    `ORB_ASSERT_CLK(a_reset_opens_input, !i_rst_n |=> !o_stall, "input stalled after reset")

    `ORB_ASSERT_RST(a_result_held, o_valid && i_stall |=> o_valid, "stalled result dropped")

    `ORB_ASSERT_RST(a_result_stable, o_valid && i_stall |=> $stable(res_bus), "stalled result moved")

endmodule

bind orbit_camera_position_top orb_checker u_checker (.*);
